@@ design/tts_pkg.sv @@
package tts_pkg;

    // Field widths of the input and result words.
    localparam int FUNC_W      = 2;
    localparam int SESSION_W   = 16;
    localparam int BYTES_W     = 32;
    localparam int MAXW_W      = 10;
    localparam int LENGTH_W    = 16;
    localparam int ERROR_W     = 2;
    localparam int DATA_W      = 64;
    localparam int KEEP_W      = 8;
    localparam int WORDS_W     = 11;
    localparam int PHASE_W     = 2;

    // Packet words are 512 bits, so lengths convert to words by a shift of six.
    localparam int BYTES_PER_WORD = 512 / 8;
    localparam int WORD_SHIFT     = 6;

    // Packed widths of the stream buses, padded to whole bytes.
    localparam int S_FIELDS_W = SESSION_W + BYTES_W + MAXW_W + SESSION_W + LENGTH_W
                              + ERROR_W + DATA_W + KEEP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = SESSION_W + LENGTH_W + DATA_W + KEEP_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Input word kinds.
    localparam logic [FUNC_W-1:0] FUNC_CMD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NOTICE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_WORD   = 2'd3;

    // Result word kinds.
    localparam logic [FUNC_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [FUNC_W-1:0] KIND_REQ    = 2'd1;
    localparam logic [FUNC_W-1:0] KIND_DATA   = 2'd2;
    localparam logic [FUNC_W-1:0] KIND_REJECT = 2'd3;

    // Status error codes.
    localparam logic [ERROR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERROR_W-1:0] ERR_TEARDOWN = 2'd1;

    // Segmenter phases.
    localparam logic [PHASE_W-1:0] PH_WAIT_CMD    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_FIRST  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_STATUS = 2'd2;
    localparam logic [PHASE_W-1:0] PH_WRITE       = 2'd3;

    // One classified word as it travels from the front end to the back end.
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [SESSION_W-1:0] session;
        logic [BYTES_W-1:0]   total_bytes;
        logic [MAXW_W-1:0]    max_words;
        logic [LENGTH_W-1:0]  length;
        logic [WORDS_W-1:0]   length_words;
        logic [ERROR_W-1:0]   error;
        logic [DATA_W-1:0]    data;
        logic [KEEP_W-1:0]    keep;
    } item_t;

endpackage

@@ design/tcp_tx_segmenter_core.sv @@
// Transmit segmenter: splits one message into packets for a transmit engine.
// Input stream s_axis carries commands, data-available notices, statuses and
// data words; tuser gives the kind of each word. Output stream m_axis returns
// exactly one result word per input word: nothing, a length request, a
// forwarded data word (tlast on the packet's final word) or a reject, with
// tuser giving the kind. A rejected word changes no state and must be resent.
// Throughput is one word per cycle in both directions when nothing stalls. A
// word accepted on s_axis passes through the input register and the queue and
// then sits in the result register on m_axis. The front end only registers and
// classifies; all state is updated by the back end, which sets the rate. The
// queue between them holds QUEUE_DEPTH words, so when the receiver stalls the
// block keeps taking input until the queue and input register are full, then
// drops s_axis_tready. Reset clears the phase to waiting for a command and
// zeroes all counters; no results are pending after reset.
module tcp_tx_segmenter_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0: cmd_session, total_bytes, max_words, status_session,
    // status_length, status_error, word_data, word_keep, zero padding.
    input  logic [tts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: func.
    input  logic [tts_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata from bit 0: req_session, req_length, out_data, out_keep.
    output logic [tts_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: out_kind.
    output logic [tts_pkg::FUNC_W-1:0]    m_axis_tuser,
    output logic                          m_axis_tlast
);

    logic           push_valid;
    logic           push_ready;
    tts_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    tts_pkg::item_t pop_item;

    // Front end: input register and classification.
    tts_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // Queue between front and back ends.
    tts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back end: segmenter state machine and result register.
    tts_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ design/tts_front.sv @@
module tts_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0: cmd_session, total_bytes, max_words, status_session,
    // status_length, status_error, word_data, word_keep, zero padding.
    input  logic [tts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: func.
    input  logic [tts_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tts_pkg::item_t                push_item
);

    logic           valid_reg;
    logic           valid_next;
    tts_pkg::item_t item_reg;
    tts_pkg::item_t item_next;
    logic           take;

    logic [tts_pkg::SESSION_W-1:0] cmd_session;
    logic [tts_pkg::BYTES_W-1:0]   total_bytes;
    logic [tts_pkg::MAXW_W-1:0]    max_words;
    logic [tts_pkg::SESSION_W-1:0] status_session;
    logic [tts_pkg::LENGTH_W-1:0]  status_length;
    logic [tts_pkg::ERROR_W-1:0]   status_error;
    logic [tts_pkg::DATA_W-1:0]    word_data;
    logic [tts_pkg::KEEP_W-1:0]    word_keep;
    logic [tts_pkg::LENGTH_W:0]    length_round;

    // Unpack the input bus.
    assign cmd_session    = s_axis_tdata[15:0];
    assign total_bytes    = s_axis_tdata[47:16];
    assign max_words      = s_axis_tdata[57:48];
    assign status_session = s_axis_tdata[73:58];
    assign status_length  = s_axis_tdata[89:74];
    assign status_error   = s_axis_tdata[91:90];
    assign word_data      = s_axis_tdata[155:92];
    assign word_keep      = s_axis_tdata[163:156];

    // The stage takes a word when empty or when its word moves on.
    assign s_axis_tready = !valid_reg || push_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Round the granted length up to whole packet words.
    assign length_round = {1'b0, status_length}
                        + (tts_pkg::LENGTH_W+1)'(tts_pkg::BYTES_PER_WORD - 1);

    // Classify the word: pick the session that goes with its kind.
    always_comb
    begin
        item_next              = item_reg;
        valid_next             = valid_reg;
        if (push_valid && push_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next             = 1'b1;
            item_next.func         = s_axis_tuser;
            item_next.session      = (s_axis_tuser == tts_pkg::FUNC_STATUS) ?
                                     status_session : cmd_session;
            item_next.total_bytes  = total_bytes;
            item_next.max_words    = max_words;
            item_next.length       = status_length;
            item_next.length_words = length_round[tts_pkg::LENGTH_W:tts_pkg::WORD_SHIFT];
            item_next.error        = status_error;
            item_next.data         = word_data;
            item_next.keep         = word_keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

@@ design/tts_queue.sv @@
module tts_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tts_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tts_pkg::item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tts_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued words.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/tts_back.sv @@
module tts_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  tts_pkg::item_t                pop_item,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata from bit 0: req_session, req_length, out_data, out_keep.
    output logic [tts_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: out_kind.
    output logic [tts_pkg::FUNC_W-1:0]    m_axis_tuser,
    output logic                          m_axis_tlast
);

    // Segmenter state.
    logic [tts_pkg::PHASE_W-1:0]   phase_reg,       phase_next;
    logic [tts_pkg::SESSION_W-1:0] session_reg,     session_next;
    logic [tts_pkg::BYTES_W-1:0]   total_reg,       total_next;
    logic [tts_pkg::MAXW_W-1:0]    limit_reg,       limit_next;
    logic [tts_pkg::BYTES_W-1:0]   sent_reg,        sent_next;
    logic [tts_pkg::WORDS_W-1:0]   pkt_words_reg,   pkt_words_next;
    logic [tts_pkg::WORDS_W-1:0]   words_sent_reg,  words_sent_next;

    // Output register.
    logic                          out_valid_reg,   out_valid_next;
    logic [tts_pkg::FUNC_W-1:0]    out_kind_reg,    out_kind_next;
    logic [tts_pkg::SESSION_W-1:0] out_session_reg, out_session_next;
    logic [tts_pkg::LENGTH_W-1:0]  out_length_reg,  out_length_next;
    logic [tts_pkg::DATA_W-1:0]    out_data_reg,    out_data_next;
    logic [tts_pkg::KEEP_W-1:0]    out_keep_reg,    out_keep_next;
    logic                          out_last_reg,    out_last_next;

    logic                          fire;
    logic [tts_pkg::LENGTH_W-1:0]  limit_bytes;
    logic [tts_pkg::BYTES_W-1:0]   sum;
    logic [tts_pkg::BYTES_W-1:0]   remain;
    logic                          more;
    logic [tts_pkg::WORDS_W-1:0]   words_inc;
    logic                          last;

    // A queued word is executed whenever the output register can take its result.
    assign pop_ready = !out_valid_reg || m_axis_tready;
    assign fire      = pop_valid && pop_ready;

    // Packet limit in bytes and the running byte count after a success.
    assign limit_bytes = {limit_reg, tts_pkg::WORD_SHIFT'(0)};
    assign sum         = sent_reg + tts_pkg::BYTES_W'(pop_item.length);
    assign remain      = total_reg - sum;
    assign more        = (sum < total_reg);
    assign words_inc   = words_sent_reg + 1'b1;
    assign last        = (words_inc == pkt_words_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        session_next     = session_reg;
        total_next       = total_reg;
        limit_next       = limit_reg;
        sent_next        = sent_reg;
        pkt_words_next   = pkt_words_reg;
        words_sent_next  = words_sent_reg;
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_session_next = out_session_reg;
        out_length_next  = out_length_reg;
        out_data_next    = out_data_reg;
        out_keep_next    = out_keep_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            out_valid_next   = 1'b1;
            out_kind_next    = tts_pkg::KIND_REJECT;
            out_session_next = '0;
            out_length_next  = '0;
            out_data_next    = '0;
            out_keep_next    = '0;
            out_last_next    = 1'b0;

            case (pop_item.func)
                tts_pkg::FUNC_CMD:
                begin
                    if (phase_reg == tts_pkg::PH_WAIT_CMD)
                    begin
                        session_next  = pop_item.session;
                        total_next    = pop_item.total_bytes;
                        limit_next    = pop_item.max_words;
                        phase_next    = tts_pkg::PH_WAIT_FIRST;
                        out_kind_next = tts_pkg::KIND_NONE;
                    end
                end
                tts_pkg::FUNC_NOTICE:
                begin
                    // First request: the packet limit or the whole message if smaller.
                    if (phase_reg == tts_pkg::PH_WAIT_FIRST)
                    begin
                        out_kind_next    = tts_pkg::KIND_REQ;
                        out_session_next = session_reg;
                        out_length_next  =
                            (tts_pkg::BYTES_W'(limit_bytes) > total_reg) ?
                            total_reg[tts_pkg::LENGTH_W-1:0] : limit_bytes;
                        phase_next       = tts_pkg::PH_WAIT_STATUS;
                    end
                end
                tts_pkg::FUNC_STATUS:
                begin
                    if (phase_reg == tts_pkg::PH_WAIT_STATUS)
                    begin
                        session_next   = pop_item.session;
                        pkt_words_next = pop_item.length_words;
                        if (pop_item.error == tts_pkg::ERR_OK)
                        begin
                            // Success: count the bytes and ask for the next packet if any bytes remain.
                            sent_next  = sum;
                            phase_next = tts_pkg::PH_WRITE;
                            if (more)
                            begin
                                out_kind_next    = tts_pkg::KIND_REQ;
                                out_session_next = pop_item.session;
                                out_length_next  =
                                    (tts_pkg::BYTES_W'(limit_bytes) < remain) ?
                                    limit_bytes : remain[tts_pkg::LENGTH_W-1:0];
                            end
                            else
                            begin
                                out_kind_next = tts_pkg::KIND_NONE;
                            end
                        end
                        else if (pop_item.error == tts_pkg::ERR_TEARDOWN)
                        begin
                            out_kind_next = tts_pkg::KIND_NONE;
                        end
                        else
                        begin
                            // Retry: ask for the same length again.
                            out_kind_next    = tts_pkg::KIND_REQ;
                            out_session_next = pop_item.session;
                            out_length_next  = pop_item.length;
                        end
                    end
                end
                default:
                begin
                    // Data word: forward it and mark the final word of the packet.
                    if (phase_reg == tts_pkg::PH_WRITE)
                    begin
                        out_kind_next   = tts_pkg::KIND_DATA;
                        out_data_next   = pop_item.data;
                        out_keep_next   = pop_item.keep;
                        out_last_next   = last;
                        words_sent_next = words_inc;
                        if (last)
                        begin
                            words_sent_next = '0;
                            if (sent_reg >= total_reg)
                            begin
                                sent_next      = '0;
                                pkt_words_next = '0;
                                phase_next     = tts_pkg::PH_WAIT_CMD;
                            end
                            else
                            begin
                                phase_next = tts_pkg::PH_WAIT_STATUS;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tts_pkg::PH_WAIT_CMD;
            session_reg    <= '0;
            total_reg      <= '0;
            limit_reg      <= '0;
            sent_reg       <= '0;
            pkt_words_reg  <= '0;
            words_sent_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            session_reg    <= session_next;
            total_reg      <= total_next;
            limit_reg      <= limit_next;
            sent_reg       <= sent_next;
            pkt_words_reg  <= pkt_words_next;
            words_sent_reg <= words_sent_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg    <= out_kind_next;
        out_session_reg <= out_session_next;
        out_length_reg  <= out_length_next;
        out_data_reg    <= out_data_next;
        out_keep_reg    <= out_keep_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_keep_reg, out_data_reg, out_length_reg, out_session_reg};

`ifndef SYNTHESIS
    // Between messages the byte and packet counters are back at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tts_pkg::PH_WAIT_CMD) |-> (sent_reg == '0 && pkt_words_reg == '0))
        else $error("counters not cleared while waiting for a command");

    // The word counter runs only while a packet is being written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != tts_pkg::PH_WRITE) |-> (words_sent_reg == '0))
        else $error("word counter nonzero outside packet write");

    // A queued word is executed only when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule

@@ dv/tcp_tx_segmenter_checker.sv @@
module tcp_tx_segmenter_checker
    import tts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [FUNC_W-1:0]    s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [FUNC_W-1:0]    m_axis_tuser,
    input  logic                 m_axis_tlast,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Input word fields, listed from the top bit down.
    typedef struct packed {
        logic [S_TDATA_W-S_FIELDS_W-1:0] pad;
        logic [KEEP_W-1:0]               keep;
        logic [DATA_W-1:0]               data;
        logic [ERROR_W-1:0]              status_error;
        logic [LENGTH_W-1:0]             status_length;
        logic [SESSION_W-1:0]            status_session;
        logic [MAXW_W-1:0]               max_words;
        logic [BYTES_W-1:0]              total_bytes;
        logic [SESSION_W-1:0]            cmd_session;
    } seg_fields_t;

    typedef struct packed {
        logic [FUNC_W-1:0]    kind;
        logic [SESSION_W-1:0] session;
        logic [LENGTH_W-1:0]  length;
        logic [DATA_W-1:0]    data;
        logic [KEEP_W-1:0]    keep;
        logic                 last;
    } seg_result_t;

    // Shadow copy of the segmenter state.
    logic [PHASE_W-1:0]   phase_now;
    logic [SESSION_W-1:0] session_now;
    logic [BYTES_W-1:0]   message_bytes;
    logic [MAXW_W-1:0]    limit_words;
    logic [BYTES_W-1:0]   bytes_granted;
    logic [WORDS_W-1:0]   packet_len_words;
    logic [WORDS_W-1:0]   words_forwarded;

    seg_result_t awaited_results[$];
    seg_result_t observed;
    seg_result_t oldest;
    int          wrong_results = 0;
    int          pending_count = 0;

    assign mismatches  = wrong_results;
    assign outstanding = pending_count;

    // Applies one accepted input word to the shadow state and returns the
    // result word the block owes for it.
    function automatic seg_result_t segmenter_response(input logic [FUNC_W-1:0] func,
                                                       input seg_fields_t f);
        seg_result_t          r;
        logic [63:0]          limit_bytes;
        logic [BYTES_W-1:0]   remaining;
        logic [LENGTH_W:0]    rounded;
        r = '0;
        limit_bytes = 64'(limit_words) << WORD_SHIFT;
        case (func)
            FUNC_CMD:
            begin
                if (phase_now != PH_WAIT_CMD)
                begin
                    r.kind = KIND_REJECT;
                end
                else
                begin
                    session_now   = f.cmd_session;
                    message_bytes = f.total_bytes;
                    limit_words   = f.max_words;
                    phase_now     = PH_WAIT_FIRST;
                    r.kind        = KIND_NONE;
                end
            end
            FUNC_NOTICE:
            begin
                if (phase_now != PH_WAIT_FIRST)
                begin
                    r.kind = KIND_REJECT;
                end
                else
                begin
                    // First request: the packet limit, or the whole message if smaller.
                    r.kind    = KIND_REQ;
                    r.session = session_now;
                    r.length  = (limit_bytes > 64'(message_bytes)) ?
                                message_bytes[LENGTH_W-1:0] : limit_bytes[LENGTH_W-1:0];
                    phase_now = PH_WAIT_STATUS;
                end
            end
            FUNC_STATUS:
            begin
                if (phase_now != PH_WAIT_STATUS)
                begin
                    r.kind = KIND_REJECT;
                end
                else
                begin
                    // Every status takes over the session and sets the packet size.
                    session_now      = f.status_session;
                    rounded          = {1'b0, f.status_length}
                                     + (LENGTH_W+1)'(BYTES_PER_WORD - 1);
                    packet_len_words = WORDS_W'(rounded >> WORD_SHIFT);
                    if (f.status_error == ERR_OK)
                    begin
                        bytes_granted = bytes_granted + BYTES_W'(f.status_length);
                        if (bytes_granted < message_bytes)
                        begin
                            remaining = message_bytes - bytes_granted;
                            r.kind    = KIND_REQ;
                            r.session = session_now;
                            r.length  = (64'(bytes_granted) + limit_bytes < 64'(message_bytes)) ?
                                        limit_bytes[LENGTH_W-1:0] : remaining[LENGTH_W-1:0];
                        end
                        else
                        begin
                            r.kind = KIND_NONE;
                        end
                        phase_now = PH_WRITE;
                    end
                    else if (f.status_error == ERR_TEARDOWN)
                    begin
                        r.kind = KIND_NONE;
                    end
                    else
                    begin
                        // Retry: ask for the same length again.
                        r.kind    = KIND_REQ;
                        r.session = session_now;
                        r.length  = f.status_length;
                    end
                end
            end
            default:
            begin
                if (phase_now != PH_WRITE)
                begin
                    r.kind = KIND_REJECT;
                end
                else
                begin
                    words_forwarded = words_forwarded + 1'b1;
                    r.kind = KIND_DATA;
                    r.data = f.data;
                    r.keep = f.keep;
                    r.last = (words_forwarded == packet_len_words);
                    if (r.last)
                    begin
                        words_forwarded = '0;
                        if (bytes_granted >= message_bytes)
                        begin
                            bytes_granted    = '0;
                            packet_len_words = '0;
                            phase_now        = PH_WAIT_CMD;
                        end
                        else
                        begin
                            phase_now = PH_WAIT_STATUS;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Result words are matched against the oldest expectation first, then
    // the input word of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_now        = PH_WAIT_CMD;
            session_now      = '0;
            message_bytes    = '0;
            limit_words      = '0;
            bytes_granted    = '0;
            packet_len_words = '0;
            words_forwarded  = '0;
            awaited_results.delete();
            pending_count    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed.kind    = m_axis_tuser;
                observed.session = m_axis_tdata[SESSION_W-1:0];
                observed.length  = m_axis_tdata[SESSION_W +: LENGTH_W];
                observed.data    = m_axis_tdata[SESSION_W+LENGTH_W +: DATA_W];
                observed.keep    = m_axis_tdata[SESSION_W+LENGTH_W+DATA_W +: KEEP_W];
                observed.last    = m_axis_tlast;
                if (awaited_results.size() == 0)
                begin
                    wrong_results++;
                    if (wrong_results <= 10)
                        $display("%0t: result word kind %0d arrived with nothing outstanding",
                                 $realtime, observed.kind);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (observed.kind != oldest.kind || observed.session != oldest.session ||
                        observed.length != oldest.length || observed.data != oldest.data ||
                        observed.keep != oldest.keep || observed.last != oldest.last)
                    begin
                        wrong_results++;
                        if (wrong_results <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected kind %0d session %h length %h data %h keep %h last %0d",
                                     oldest.kind, oldest.session, oldest.length,
                                     oldest.data, oldest.keep, oldest.last);
                            $display("  actual   kind %0d session %h length %h data %h keep %h last %0d",
                                     observed.kind, observed.session, observed.length,
                                     observed.data, observed.keep, observed.last);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(segmenter_response(s_axis_tuser,
                                                             seg_fields_t'(s_axis_tdata)));
            pending_count = awaited_results.size();
        end
    end

endmodule

@@ dv/tcp_tx_segmenter_core_test.sv @@
module tcp_tx_segmenter_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tts_pkg::*;

    localparam int ITEM_TARGET  = 1650;
    localparam int CALM_FROM    = 1400;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;

    // Failed statuses that ask for the same length again.
    localparam logic [ERROR_W-1:0] ERR_RETRY_LO = 2'd2;
    localparam logic [ERROR_W-1:0] ERR_RETRY_HI = 2'd3;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [FUNC_W-1:0]    s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [FUNC_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;
    int                   mismatches;
    int                   outstanding;

    // Field values of the next input word.
    logic [SESSION_W-1:0] f_cmd_session;
    logic [BYTES_W-1:0]   f_total;
    logic [MAXW_W-1:0]    f_max_words;
    logic [SESSION_W-1:0] f_status_session;
    logic [LENGTH_W-1:0]  f_length;
    logic [ERROR_W-1:0]   f_error;
    logic [DATA_W-1:0]    f_data;
    logic [KEEP_W-1:0]    f_keep;

    int useful_words   = 0;
    int quiet_cycles   = 0;
    bit long_hold_done = 1'b0;

    tcp_tx_segmenter_core u_dut (.*);

    tcp_tx_segmenter_checker u_checker (.*);

    always #5 clk = ~clk;

    // Idling stops in quiet windows and for the tail of the run.
    function automatic bit idling_allowed();
        return (useful_words < CALM_FROM) && ((useful_words % 300) < 220);
    endfunction

    function automatic logic [S_TDATA_W-1:0] packed_fields();
        return {{(S_TDATA_W-S_FIELDS_W){1'b0}}, f_keep, f_data, f_error, f_length,
                f_status_session, f_max_words, f_total, f_cmd_session};
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_word_bits();
        logic [S_TDATA_W-1:0] bits;
        bits = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        bits[S_TDATA_W-1:S_FIELDS_W] = '0;
        return bits;
    endfunction

    task automatic scramble_fields();
        f_cmd_session    = SESSION_W'($urandom);
        f_total          = $urandom;
        f_max_words      = MAXW_W'($urandom);
        f_status_session = SESSION_W'($urandom);
        f_length         = LENGTH_W'($urandom);
        f_error          = ERROR_W'($urandom);
        f_data           = {$urandom, $urandom};
        f_keep           = KEEP_W'($urandom);
    endtask

    // Offers one word and returns at the edge where it is taken.
    task automatic offer(input logic [FUNC_W-1:0] func, input logic [S_TDATA_W-1:0] bits);
        if (idling_allowed() && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= bits;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Sends a word the current phase takes, sometimes after one it rejects.
    task automatic pass_item(input logic [FUNC_W-1:0] func);
        logic [FUNC_W-1:0] wrong;
        if ($urandom_range(0, 9) == 0)
        begin
            do wrong = FUNC_W'($urandom_range(0, 3)); while (wrong == func);
            offer(wrong, random_word_bits());
        end
        offer(func, packed_fields());
        useful_words++;
    endtask

    task automatic give_status(input logic [ERROR_W-1:0] err, input logic [LENGTH_W-1:0] len);
        scramble_fields();
        f_error  = err;
        f_length = len;
        pass_item(FUNC_STATUS);
    endtask

    task automatic give_words(input int count);
        repeat (count)
        begin
            scramble_fields();
            pass_item(FUNC_WORD);
        end
    endtask

    // One message: command, notice, then packets until the bytes are covered
    // or the packet cap is hit. Failed statuses are mixed in at random.
    task automatic run_message(input logic [SESSION_W-1:0] sess, input logic [BYTES_W-1:0] total,
                               input logic [MAXW_W-1:0] maxw, input int packet_cap);
        logic [BYTES_W-1:0]  granted;
        logic [BYTES_W-1:0]  asked;
        logic [LENGTH_W-1:0] len;
        int                  packets;
        bit                  done;
        scramble_fields();
        f_cmd_session = sess;
        f_total       = total;
        f_max_words   = maxw;
        pass_item(FUNC_CMD);
        scramble_fields();
        pass_item(FUNC_NOTICE);
        granted = '0;
        packets = 0;
        done    = 1'b0;
        while (!done)
        begin
            while ($urandom_range(0, 6) == 0)
                give_status(ERROR_W'($urandom_range(ERR_TEARDOWN, ERR_RETRY_HI)),
                            LENGTH_W'($urandom_range(1, 65535)));
            asked = BYTES_W'(maxw) * BYTES_PER_WORD;
            if (total - granted < asked)
                asked = total - granted;
            if ($urandom_range(0, 39) == 0)
                len = LENGTH_W'($urandom_range(1, 4096));
            else if (asked >= 1 && asked <= 512 && $urandom_range(0, 2) != 0)
                len = asked[LENGTH_W-1:0];
            else
                len = LENGTH_W'($urandom_range(1, 256));
            give_status(ERR_OK, len);
            granted = granted + len;
            give_words((int'(len) + BYTES_PER_WORD - 1) >> WORD_SHIFT);
            packets++;
            done = (granted >= total) || (packet_cap != 0 && packets >= packet_cap);
        end
    endtask

    // Receiver: short random stalls, plus one long hold that backs up the block.
    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            if (!long_hold_done && useful_words >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idling_allowed() && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [BYTES_W-1:0] total;
        logic [MAXW_W-1:0]  maxw;
        int                 pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Words of the wrong kind straight after reset.
        offer(FUNC_WORD, random_word_bits());
        offer(FUNC_STATUS, random_word_bits());
        offer(FUNC_NOTICE, random_word_bits());

        // Empty message with the largest limit: a zero-byte request, a teardown,
        // two retries at the length extremes, then one packet of one word.
        scramble_fields();
        f_cmd_session = '1;
        f_total       = '0;
        f_max_words   = '1;
        pass_item(FUNC_CMD);
        scramble_fields();
        pass_item(FUNC_NOTICE);
        give_status(ERR_TEARDOWN, '1);
        give_status(ERR_RETRY_HI, '1);
        give_status(ERR_RETRY_LO, LENGTH_W'(1));
        give_status(ERR_OK, LENGTH_W'(1));
        scramble_fields();
        f_data = '1;
        f_keep = '1;
        offer(FUNC_CMD, packed_fields());
        pass_item(FUNC_WORD);

        // Zero packet limit: every request asks for zero bytes; the grants
        // land exactly on the message size.
        scramble_fields();
        f_cmd_session = '0;
        f_total       = BYTES_W'(200);
        f_max_words   = '0;
        pass_item(FUNC_CMD);
        scramble_fields();
        pass_item(FUNC_NOTICE);
        give_status(ERR_OK, LENGTH_W'(64));
        give_words(1);
        give_status(ERR_OK, LENGTH_W'(136));
        repeat (3)
        begin
            scramble_fields();
            f_data = '0;
            f_keep = '0;
            pass_item(FUNC_WORD);
        end

        // Random messages, mostly small sizes.
        while (useful_words < ITEM_TARGET - 40)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                total = '0;
            else if (pick <= 3)
                total = $urandom_range(600, 3000);
            else
                total = $urandom_range(1, 600);
            maxw = ($urandom_range(0, 2) == 0) ? MAXW_W'($urandom_range(5, 1023))
                                               : MAXW_W'($urandom_range(1, 4));
            run_message(SESSION_W'($urandom), total, maxw, 0);
        end

        // A huge message that is left unfinished at the end of the run.
        run_message(SESSION_W'($urandom), 32'h8000_0000 | $urandom,
                    MAXW_W'($urandom_range(512, 1023)), 3);
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
design/tts_pkg.sv
design/tts_front.sv
design/tts_queue.sv
design/tts_back.sv
design/tcp_tx_segmenter_core.sv
dv/tcp_tx_segmenter_checker.sv
dv/tcp_tx_segmenter_core_test.sv
